@@ src/ordered_id_list_pair_macros.svh @@
// ----------------------------------------------------------------------------
// ordered_id_list_pair_macros.svh
// Assertion macros used by the checker file of the id list pair.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ID_LIST_PAIR_MACROS_SVH
`define ORDERED_ID_LIST_PAIR_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define OILP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while in reset.
`define OILP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/oilp_pkg.sv @@
// ----------------------------------------------------------------------------
// oilp_pkg
// Sizes, codes and controller/datapath interface types of the id list pair.
// ----------------------------------------------------------------------------
package oilp_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    MODE_INSERT      = 2'd0,
    MODE_EXTRACT     = 2'd1,
    MODE_REMOVE_HEAD = 2'd2,
    MODE_TRANSFER    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EXEC
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic step;    // compare one entry, advance the search index on a miss
    logic commit;  // apply the list update, load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_op;  // extract or transfer
    logic empty;      // selected list holds no entry
    logic hit;        // entry under the search index matches
    logic last;       // search index is at the tail
  } stat_t;

endpackage

@@ src/oilp_ctrl.sv @@
// ----------------------------------------------------------------------------
// oilp_ctrl
// Sequencer: accept, search walk, commit; owns the result valid flag.
// ----------------------------------------------------------------------------
module oilp_ctrl import oilp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   search_done;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign search_done = !stat_i.search_op || stat_i.empty || stat_i.hit || stat_i.last;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i)  state_d = S_SEARCH;
      S_SEARCH: if (search_done) state_d = S_EXEC;
      S_EXEC:   if (slot_free)   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_SEARCH: cmd_o.step = stat_i.search_op && !stat_i.empty;
      S_EXEC:   cmd_o.commit = slot_free;
      default:  cmd_o = '0;
    endcase
  end

  assign out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/oilp_dpath.sv @@
// ----------------------------------------------------------------------------
// oilp_dpath
// Two head-first id lists in shift registers, search index, result register.
// ----------------------------------------------------------------------------
module oilp_dpath import oilp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic [1:0]          mode_i,
  input  logic                list_select_i,
  input  logic signed [ID_W-1:0] item_id_i,
  output logic [1:0]          status_o,
  output logic signed [ID_W-1:0] removed_id_o,
  output logic [COUNT_W-1:0]  count_first_o,
  output logic [COUNT_W-1:0]  count_second_o
);

  // captured transaction and search state
  mode_e            mode_q;
  logic             sel_q;
  logic [ID_W-1:0]  id_q;
  logic [IDX_W-1:0] idx_q;
  logic             found_q;

  // list storage and sizes
  logic [ID_W-1:0]  ids     [2][CAPACITY];
  logic [CNT_W-1:0] size_q  [2];
  logic [CNT_W-1:0] size_d  [2];

  // result register
  status_e          status_q;
  logic [ID_W-1:0]  removed_q;
  logic [COUNT_W-1:0] count_first_q, count_second_q;

  // commit decode
  logic [CNT_W-1:0] n_sel, n_other;
  logic [ID_W-1:0]  cur;
  logic             hit;
  status_e          status_d;
  logic [ID_W-1:0]  removed_d;
  logic [1:0]       push_en, take_en;
  logic [IDX_W-1:0] take_pos;
  logic [ID_W-1:0]  push_val;

  assign n_sel   = size_q[sel_q];
  assign n_other = size_q[!sel_q];
  assign cur     = ids[sel_q][idx_q];
  assign hit     = (cur == id_q);

  assign stat_o.search_op = (mode_q == MODE_EXTRACT) || (mode_q == MODE_TRANSFER);
  assign stat_o.empty     = (n_sel == '0);
  assign stat_o.hit       = hit;
  assign stat_o.last      = (CNT_W'(idx_q) + CNT_W'(1)) == n_sel;

  always_comb begin
    status_d  = ST_OK;
    removed_d = '0;
    push_en   = '0;
    take_en   = '0;
    take_pos  = idx_q;
    push_val  = id_q;
    unique case (mode_q) inside
      MODE_INSERT: begin
        if (n_sel == CNT_W'(CAPACITY)) status_d = ST_FULL;
        else push_en[sel_q] = 1'b1;
      end
      MODE_REMOVE_HEAD: begin
        if (n_sel == '0) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d      = ids[sel_q][0];
          take_en[sel_q] = 1'b1;
          take_pos       = '0;
        end
      end
      MODE_EXTRACT, MODE_TRANSFER: begin
        if (n_sel == '0) begin
          status_d = ST_EMPTY;
        end else if (!found_q) begin
          status_d = ST_NOT_FOUND;
        end else if (mode_q == MODE_TRANSFER && n_other == CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          removed_d      = cur;
          take_en[sel_q] = 1'b1;
          push_val       = cur;
          if (mode_q == MODE_TRANSFER) push_en[!sel_q] = 1'b1;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      size_d[l] = size_q[l];
      if (push_en[l])      size_d[l] = size_q[l] + CNT_W'(1);
      else if (take_en[l]) size_d[l] = size_q[l] - CNT_W'(1);
    end
  end

  // Per-entry shift cells: push moves everything one place toward the tail,
  // take closes the gap from take_pos onward.
  for (genvar l = 0; l < 2; l++) begin : g_list
    for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
      logic [ID_W-1:0] entry_q;
      logic [ID_W-1:0] from_head, from_tail;

      if (i == 0) begin : g_head
        assign from_head = push_val;
      end else begin : g_body
        assign from_head = ids[l][i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign from_tail = entry_q;
      end else begin : g_mid
        assign from_tail = ids[l][i+1];
      end

      always_ff @(posedge clk_i) begin
        if (cmd_i.commit) begin
          if (push_en[l]) begin
            entry_q <= from_head;
          end else if (take_en[l] && (IDX_W'(i) >= take_pos)) begin
            entry_q <= from_tail;
          end
        end
      end

      assign ids[l][i] = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= '0;
      size_q[1] <= '0;
    end else if (cmd_i.commit) begin
      size_q[0] <= size_d[0];
      size_q[1] <= size_d[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_e'(mode_i);
      sel_q   <= list_select_i;
      id_q    <= item_id_i;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (hit) found_q <= 1'b1;
      else     idx_q   <= idx_q + IDX_W'(1);
    end
    if (cmd_i.commit) begin
      status_q       <= status_d;
      removed_q      <= removed_d;
      count_first_q  <= COUNT_W'(size_d[0]);
      count_second_q <= COUNT_W'(size_d[1]);
    end
  end

  assign status_o       = status_q;
  assign removed_id_o   = $signed(removed_q);
  assign count_first_o  = count_first_q;
  assign count_second_o = count_second_q;

endmodule

@@ src/ordered_id_list_pair.sv @@
// ----------------------------------------------------------------------------
// ordered_id_list_pair - two head-first id lists with insert/extract/pop/move.
// Insert and remove head: no search walk between accept and result.
// Extract and transfer: the search walks from the head to a match or the tail;
// one list entry is compared per cycle, so the search walk sets the rate.
// Reset (async, low) empties both lists and drops any pending result.
// ----------------------------------------------------------------------------
module ordered_id_list_pair import oilp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             mode_i,
  input  logic                   list_select_i,
  input  logic signed [ID_W-1:0] item_id_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic signed [ID_W-1:0] removed_id_o,
  output logic [COUNT_W-1:0]     count_first_o,
  output logic [COUNT_W-1:0]     count_second_o
);

  // One transaction is worked at a time. The controller walks:
  //   IDLE   - stall low, a request is captured into the datapath
  //   SEARCH - extract/transfer compare one entry per cycle from the head;
  //            other modes (and an empty list) pass straight through
  //   EXEC   - list update and result register load, held until the
  //            result slot is free
  // The result sits in its own register, so the next request is taken
  // while the previous result still waits on out_stall_i.
  //
  // Lists live in per-entry shift registers, entry 0 is the head. Entries
  // beyond the fill count are never read, so they need no reset.

  cmd_t  cmd;
  stat_t stat;

  oilp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  oilp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .mode_i         (mode_i),
    .list_select_i  (list_select_i),
    .item_id_i      (item_id_i),
    .status_o       (status_o),
    .removed_id_o   (removed_id_o),
    .count_first_o  (count_first_o),
    .count_second_o (count_second_o)
  );

endmodule

@@ src/oilp_checker.sv @@
// ----------------------------------------------------------------------------
// oilp_checker
// Port-level checks of the id list pair, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_id_list_pair_macros.svh"

module oilp_checker import oilp_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [1:0]             status_o,
  input logic signed [ID_W-1:0] removed_id_o,
  input logic [COUNT_W-1:0]     count_first_o,
  input logic [COUNT_W-1:0]     count_second_o
);

  // an accepted request keeps the input side busy in the following cycle
  `OILP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted request did not block the next one")

  // a new result only appears out of a busy cycle
  `OILP_ASSERT_SAME(a_result_from_work, $rose(out_valid_o), $past(in_stall_o), "result appeared without work")

  // removed id is zero unless the status is ok
  `OILP_ASSERT_SAME(a_removed_zero, out_valid_o && (status_o != ST_OK), removed_id_o == '0, "removed id set on failed transaction")

  // stalled result holds
  `OILP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(removed_id_o) && $stable(count_first_o) && $stable(count_second_o), "stalled result changed")

endmodule

bind ordered_id_list_pair oilp_checker u_checker (.*);
